// ===== hw/rtl/sdta_pkg.sv =====
`default_nettype none
package sdta_pkg;

  // default operand width
  localparam int DefaultValueWidth = 32;

  // ascii codes
  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharMinus = 8'd45;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic scan;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic conv_done;
    logic neg;
    logic digit_last;
  } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sdta_if.sv =====
`default_nettype none
// input channel: one signed integer per request
interface sdta_in_if #(
  parameter int ValueWidth = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [ValueWidth-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// output channel: one ascii character per request
interface sdta_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink (input valid, input char_code, input last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/signed_decimal_to_ascii_core.sv =====
`default_nettype none
// Signed decimal to ASCII text converter.
// din carries one signed VALUE_WIDTH-bit integer per request; dout returns
// its decimal text one character per request, most significant first,
// with a leading '-' for negative values and last set on the final digit.
// Zero gives the single character '0'; no leading zeros are produced.
// A request on din is taken only while the block is idle. The magnitude
// is then converted to BCD by shift-add-3, four bits per cycle, and the
// leading digit is found. The first character is then loaded into the
// output register once that register can take it. At 32 bits an item
// gives up to 11 characters. Characters go through an output register
// that holds its request while dout.ready is low; the block waits without
// losing or repeating characters and takes the next din request once the
// last character has been loaded into that register.
// Reset (rst, synchronous) returns the controller to idle and drops
// dout.valid; nothing else is kept between items.
module signed_decimal_to_ascii_core #(
  parameter int VALUE_WIDTH = sdta_pkg::DefaultValueWidth
) (
  input  logic       clk,
  input  logic       rst,
  sdta_in_if.sink    din,
  sdta_out_if.source dout
);
  import sdta_pkg::*;

  cmd_t    cmd;
  status_t status;

  sdta_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .status    (status),
    .cmd       (cmd)
  );

  sdta_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .value     (VALUE_WIDTH'(din.value)),
    .cmd       (cmd),
    .status    (status),
    .char_code (dout.char_code),
    .last      (dout.last)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/sdta_ctrl.sv =====
`default_nettype none
module sdta_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  sdta_pkg::status_t status,
  output sdta_pkg::cmd_t    cmd
);
  import sdta_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StConv  = 3'd1;
  localparam logic [2:0] StScan  = 3'd2;
  localparam logic [2:0] StSign  = 3'd3;
  localparam logic [2:0] StDigit = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;
  logic       out_free;

  assign in_ready = (state == StIdle);
  // output register can take a new character
  assign out_free = !out_valid || out_ready;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      StIdle: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = StConv;
        end
      end
      StConv: begin
        cmd.step = 1'b1;
        if (status.conv_done) begin
          state_next = StScan;
        end
      end
      StScan: begin
        cmd.scan   = 1'b1;
        state_next = status.neg ? StSign : StDigit;
      end
      StSign: begin
        if (out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = StDigit;
        end
      end
      StDigit: begin
        if (out_free) begin
          cmd.emit_digit = 1'b1;
          if (status.digit_last) begin
            state_next = StIdle;
          end
        end
      end
      default: begin
        state_next = StIdle;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StIdle;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sdta_datapath.sv =====
`default_nettype none
module sdta_datapath #(
  parameter int VALUE_WIDTH = sdta_pkg::DefaultValueWidth
) (
  input  logic                          clk,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  sdta_pkg::cmd_t                cmd,
  output sdta_pkg::status_t             status,
  output logic [7:0]                    char_code,
  output logic                          last
);
  import sdta_pkg::*;

  // magnitude padded to whole nibbles, four bits shifted per cycle
  localparam int PadW      = ((VALUE_WIDTH + 3) / 4) * 4;
  localparam int NumSteps  = PadW / 4;
  localparam int CntW      = $clog2(NumSteps);
  localparam int NumDigits = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int BcdW      = NumDigits * 4;
  localparam int IdxW      = $clog2(NumDigits);

  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] abs_val;
  logic [PadW-1:0]        mag;
  logic [BcdW-1:0]        bcd;
  logic [BcdW-1:0]        bcd_next;
  logic [PadW-1:0]        mag_next;
  logic                   neg;
  logic [CntW-1:0]        cnt;
  logic [IdxW-1:0]        idx;
  logic [IdxW-1:0]        msd;
  logic [3:0]             digit;

  // magnitude as unsigned negation, so the most negative value fits
  assign raw     = value;
  assign abs_val = raw[VALUE_WIDTH-1] ? VALUE_WIDTH'(~raw + 1'b1) : raw;

  // four shift-add-3 steps per cycle
  always_comb begin
    logic [BcdW-1:0] b;
    logic [PadW-1:0] m;
    b = bcd;
    m = mag;
    for (int k = 0; k < 4; k++) begin
      for (int d = 0; d < NumDigits; d++) begin
        if (b[d*4 +: 4] >= 4'd5) begin
          b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
        end
      end
      b = {b[BcdW-2:0], m[PadW-1]};
      m = {m[PadW-2:0], 1'b0};
    end
    bcd_next = b;
    mag_next = m;
  end

  // most significant nonzero digit, zero when all digits are zero
  always_comb begin
    msd = '0;
    for (int d = 0; d < NumDigits; d++) begin
      if (bcd[d*4 +: 4] != 4'd0) begin
        msd = IdxW'(d);
      end
    end
  end

  assign digit = bcd[idx*4 +: 4];

  assign status.conv_done  = (cnt == '0);
  assign status.neg        = neg;
  assign status.digit_last = (idx == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= PadW'(abs_val);
      bcd <= '0;
      neg <= raw[VALUE_WIDTH-1];
      cnt <= CntW'(NumSteps - 1);
    end else if (cmd.step) begin
      mag <= mag_next;
      bcd <= bcd_next;
      cnt <= cnt - 1'b1;
    end
    if (cmd.scan) begin
      idx <= msd;
    end else if (cmd.emit_digit) begin
      idx <= idx - 1'b1;
    end
    if (cmd.emit_sign) begin
      char_code <= CharMinus;
      last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      char_code <= CharZero + {4'b0000, digit};
      last      <= (idx == '0);
    end
  end

endmodule
`default_nettype wire
